// ----- rtl/bgs_pkg.sv -----
package bgs_pkg;

  // store geometry
  localparam int MAX_PIXELS = 524288;
  localparam int IDX_W      = $clog2(MAX_PIXELS);
  localparam int PIX_IDX_W  = 19;
  localparam int CH_W       = 8;
  localparam int NUM_CH     = 3;
  localparam int CNT_W      = 8;
  localparam int ENTRY_W    = NUM_CH * (CH_W + CNT_W);
  localparam int BG_LSB     = 0;
  localparam int CNT_LSB    = NUM_CH * CH_W;

  // stream widths
  localparam int IN_DATA_W  = 48;
  localparam int RES_W      = NUM_CH + NUM_CH * CH_W;
  localparam int OUT_DATA_W = 32;

  // configuration register indexes
  localparam logic [1:0] REG_COLOR_MODE     = 2'd0;
  localparam logic [1:0] REG_DIFF_THRESHOLD = 2'd1;
  localparam logic [1:0] REG_BLEND_WEIGHT   = 2'd2;
  localparam logic [1:0] REG_GHOST_LIMIT    = 2'd3;

  // Q1.8 one, also the "never replace" ghost limit
  localparam logic [8:0] Q8_ONE     = 9'd256;
  localparam logic [16:0] Q8_HALF   = 17'd128;

  // reset values of the registers
  localparam logic       RST_COLOR_MODE     = 1'b0;
  localparam logic [7:0] RST_DIFF_THRESHOLD = 8'd25;
  localparam logic [8:0] RST_BLEND_WEIGHT   = 9'd13;
  localparam logic [8:0] RST_GHOST_LIMIT    = 9'd50;

  // output queue
  localparam int OQ_DEPTH = 4;
  localparam int OQ_PTR_W = $clog2(OQ_DEPTH);
  localparam int OQ_CNT_W = OQ_PTR_W + 1;

  typedef struct packed {
    logic       color_mode;
    logic [7:0] diff_threshold;
    logic [8:0] blend_weight;
    logic [8:0] ghost_limit;
  } cfg_t;

endpackage

// ----- rtl/bgs_mem.sv -----
module bgs_mem (
  input  logic                            clk,
  input  logic                            rd_en,
  input  logic [bgs_pkg::IDX_W-1:0]       rd_addr,
  output logic [bgs_pkg::ENTRY_W-1:0]     rd_data_r,
  input  logic                            wr_en,
  input  logic [bgs_pkg::IDX_W-1:0]       wr_addr,
  input  logic [bgs_pkg::ENTRY_W-1:0]     wr_data
);

  logic [bgs_pkg::ENTRY_W-1:0] store [bgs_pkg::MAX_PIXELS];

  // single write port
  always_ff @(posedge clk) begin
    if (wr_en) begin
      store[wr_addr] <= wr_data;
    end
  end

  // registered read, old data on a same-address collision
  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data_r <= store[rd_addr];
    end
  end

endmodule

// ----- rtl/bgs_chan.sv -----
module bgs_chan (
  input  bgs_pkg::cfg_t                cfg,
  input  logic                         active,
  input  logic                         first,
  input  logic [bgs_pkg::CH_W-1:0]     pix,
  input  logic [bgs_pkg::CH_W-1:0]     bg_old,
  input  logic [bgs_pkg::CNT_W-1:0]    cnt_old,
  output logic [bgs_pkg::CH_W-1:0]     bg_new,
  output logic [bgs_pkg::CNT_W-1:0]    cnt_new,
  output logic                         fg,
  output logic [bgs_pkg::CH_W-1:0]     bg_res
);

  logic [8:0]                   alpha;
  logic [8:0]                   lim;
  logic [16:0]                  prod_pix;
  logic [16:0]                  prod_bg;
  logic [16:0]                  blend_sum;
  logic [bgs_pkg::CH_W-1:0]     blend;
  logic [bgs_pkg::CH_W-1:0]     diff;
  logic                         fg_hit;
  logic [bgs_pkg::CNT_W-1:0]    cnt_inc;
  logic                         replace;

  // saturate weight and limit at one
  assign alpha = (cfg.blend_weight > bgs_pkg::Q8_ONE) ? bgs_pkg::Q8_ONE : cfg.blend_weight;
  assign lim   = (cfg.ghost_limit > bgs_pkg::Q8_ONE) ? bgs_pkg::Q8_ONE : cfg.ghost_limit;

  // running average, rounded half up
  assign prod_pix  = 17'(alpha) * 17'(pix);
  assign prod_bg   = 17'(bgs_pkg::Q8_ONE - alpha) * 17'(bg_old);
  assign blend_sum = prod_pix + prod_bg + bgs_pkg::Q8_HALF;
  assign blend     = blend_sum[15:8];

  // foreground test on the blended background
  assign diff   = (blend > pix) ? (blend - pix) : (pix - blend);
  assign fg_hit = diff > cfg.diff_threshold;

  // ghost counter, wraps at its width
  assign cnt_inc = cnt_old + 8'd1;
  assign replace = {1'b0, cnt_inc} >= lim;

  // entry update and result
  always_comb begin
    bg_new  = bg_old;
    cnt_new = cnt_old;
    fg      = 1'b0;
    bg_res  = '0;
    if (first) begin
      bg_new  = pix;
      cnt_new = '0;
      if (active) begin
        bg_res = pix;
      end
    end else if (active) begin
      fg = fg_hit;
      if (fg_hit) begin
        cnt_new = cnt_inc;
        bg_new  = replace ? pix : blend;
      end else begin
        cnt_new = '0;
        bg_new  = blend;
      end
      bg_res = bg_new;
    end
  end

endmodule

// ----- rtl/bgs_outq.sv -----
module bgs_outq (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            push,
  input  logic [bgs_pkg::RES_W-1:0]       push_data,
  input  logic                            pop,
  output logic                            head_valid,
  output logic [bgs_pkg::RES_W-1:0]       head_data,
  output logic [bgs_pkg::OQ_CNT_W-1:0]    count
);

  logic [bgs_pkg::RES_W-1:0]     slots [bgs_pkg::OQ_DEPTH];
  logic [bgs_pkg::OQ_PTR_W-1:0]  wr_ptr_r, wr_ptr_nxt;
  logic [bgs_pkg::OQ_PTR_W-1:0]  rd_ptr_r, rd_ptr_nxt;
  logic [bgs_pkg::OQ_CNT_W-1:0]  cnt_r, cnt_nxt;
  logic                          do_pop;

  function automatic logic [bgs_pkg::OQ_CNT_W-1:0] OQ_CNT_ONE(input logic b);
    OQ_CNT_ONE = {{(bgs_pkg::OQ_CNT_W-1){1'b0}}, b};
  endfunction

  assign do_pop = pop && (cnt_r != '0);

  // pointer and fill bookkeeping
  always_comb begin
    wr_ptr_nxt = push ? wr_ptr_r + bgs_pkg::OQ_PTR_W'(1) : wr_ptr_r;
    rd_ptr_nxt = do_pop ? rd_ptr_r + bgs_pkg::OQ_PTR_W'(1) : rd_ptr_r;
    cnt_nxt    = cnt_r + OQ_CNT_ONE(push) - OQ_CNT_ONE(do_pop);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  // result slots
  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr_r] <= push_data;
    end
  end

  assign head_valid = cnt_r != '0;
  assign head_data  = slots[rd_ptr_r];
  assign count      = cnt_r;

endmodule

// ----- rtl/background_subtract_ghost_suppress_core.sv -----
// Running-average background subtraction with ghost suppression, one pixel per
// request. Each pixel reads its entry (three 8-bit backgrounds and three 8-bit
// foreground counters) from a 524288 x 48 single-port-write synchronous memory,
// updates it in the cycle after the read and writes it back; a one-entry
// bypass register covers a pixel that hits the entry written at the edge of its
// own read, so the same position may be sent back to back. Throughput is one
// pixel per clock while in_tready is high, set by the one read and one write the
// memory takes per pixel; results pass the update stage and queue in a four-entry
// output buffer, and in_tready drops only when that buffer is about to fill.
// The memory is not cleared: the first-frame flag must have written an entry
// before it is used. Configuration may be written only while no pixel is in
// flight; cfg_ready is always high.
module background_subtract_ghost_suppress_core (
  input  logic        clk,
  input  logic        rst_n,
  // input pixels
  input  logic        in_tvalid,
  output logic        in_tready,
  // [18:0] pixel_index, [26:19] sample_ch0, [34:27] sample_ch1,
  // [42:35] sample_ch2, [47:43] zero
  input  logic [47:0] in_tdata,
  // [0] first_frame
  input  logic        in_tuser,
  // results
  output logic        out_tvalid,
  input  logic        out_tready,
  // [0] fg_ch0, [1] fg_ch1, [2] fg_ch2, [10:3] bg_ch0, [18:11] bg_ch1,
  // [26:19] bg_ch2, [31:27] zero
  output logic [31:0] out_tdata,
  // configuration writes
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [1:0]  cfg_index,
  input  logic [8:0]  cfg_data
);

  localparam int NCH = bgs_pkg::NUM_CH;
  localparam int CW  = bgs_pkg::CH_W;
  localparam int KW  = bgs_pkg::CNT_W;

  bgs_pkg::cfg_t                       cfg_r;
  logic                                in_acc;
  logic [bgs_pkg::IDX_W-1:0]           rd_addr;
  logic [bgs_pkg::ENTRY_W-1:0]         rd_data;

  logic                                s1_valid_r;
  logic [bgs_pkg::IDX_W-1:0]           s1_idx_r;
  logic                                s1_first_r;
  logic [NCH-1:0][CW-1:0]              s1_pix_r;

  logic                                fwd_valid_r;
  logic [bgs_pkg::IDX_W-1:0]           fwd_idx_r;
  logic [bgs_pkg::ENTRY_W-1:0]         fwd_data_r;

  logic [bgs_pkg::ENTRY_W-1:0]         entry;
  logic [NCH-1:0][CW-1:0]              bg_old, bg_new, bg_res;
  logic [NCH-1:0][KW-1:0]              cnt_old, cnt_new;
  logic [NCH-1:0]                      fg;
  logic [NCH-1:0]                      active;
  logic [bgs_pkg::ENTRY_W-1:0]         wr_data;
  logic [bgs_pkg::RES_W-1:0]           res_data;
  logic [bgs_pkg::RES_W-1:0]           head_data;
  logic [bgs_pkg::OQ_CNT_W-1:0]        oq_count;
  logic [bgs_pkg::OQ_CNT_W:0]          in_flight;

  // configuration registers
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.color_mode     <= bgs_pkg::RST_COLOR_MODE;
      cfg_r.diff_threshold <= bgs_pkg::RST_DIFF_THRESHOLD;
      cfg_r.blend_weight   <= bgs_pkg::RST_BLEND_WEIGHT;
      cfg_r.ghost_limit    <= bgs_pkg::RST_GHOST_LIMIT;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        bgs_pkg::REG_COLOR_MODE:     cfg_r.color_mode     <= cfg_data[0];
        bgs_pkg::REG_DIFF_THRESHOLD: cfg_r.diff_threshold <= cfg_data[7:0];
        bgs_pkg::REG_BLEND_WEIGHT:   cfg_r.blend_weight   <= cfg_data;
        bgs_pkg::REG_GHOST_LIMIT:    cfg_r.ghost_limit    <= cfg_data;
        default: ;
      endcase
    end
  end

  // accept while the output queue has room for everything in flight
  assign in_flight = {1'b0, oq_count} + {{bgs_pkg::OQ_CNT_W{1'b0}}, s1_valid_r};
  assign in_tready = in_flight < (bgs_pkg::OQ_CNT_W + 1)'(bgs_pkg::OQ_DEPTH);
  assign in_acc    = in_tvalid && in_tready;
  assign rd_addr   = bgs_pkg::IDX_W'(in_tdata[bgs_pkg::PIX_IDX_W-1:0]);

  bgs_mem u_mem (
    .clk       (clk),
    .rd_en     (in_acc),
    .rd_addr   (rd_addr),
    .rd_data_r (rd_data),
    .wr_en     (s1_valid_r),
    .wr_addr   (s1_idx_r),
    .wr_data   (wr_data)
  );

  // update stage, lines up with the memory read data
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else begin
      s1_valid_r <= in_acc;
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      s1_idx_r    <= rd_addr;
      s1_first_r  <= in_tuser;
      s1_pix_r[0] <= in_tdata[26:19];
      s1_pix_r[1] <= in_tdata[34:27];
      s1_pix_r[2] <= in_tdata[42:35];
    end
  end

  // bypass of the entry written at the edge the read was taken
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fwd_valid_r <= 1'b0;
    end else if (s1_valid_r) begin
      fwd_valid_r <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_valid_r) begin
      fwd_idx_r  <= s1_idx_r;
      fwd_data_r <= wr_data;
    end
  end

  assign entry = (fwd_valid_r && (fwd_idx_r == s1_idx_r)) ? fwd_data_r : rd_data;

  // per-channel update
  assign active = {cfg_r.color_mode, cfg_r.color_mode, 1'b1};

  for (genvar k = 0; k < NCH; k++) begin : g_ch
    assign bg_old[k]  = entry[bgs_pkg::BG_LSB + k*CW +: CW];
    assign cnt_old[k] = entry[bgs_pkg::CNT_LSB + k*KW +: KW];

    bgs_chan u_chan (
      .cfg     (cfg_r),
      .active  (active[k]),
      .first   (s1_first_r),
      .pix     (s1_pix_r[k]),
      .bg_old  (bg_old[k]),
      .cnt_old (cnt_old[k]),
      .bg_new  (bg_new[k]),
      .cnt_new (cnt_new[k]),
      .fg      (fg[k]),
      .bg_res  (bg_res[k])
    );
  end

  assign wr_data  = {cnt_new[2], cnt_new[1], cnt_new[0], bg_new[2], bg_new[1], bg_new[0]};
  assign res_data = {bg_res[2], bg_res[1], bg_res[0], fg[2], fg[1], fg[0]};

  // result queue
  bgs_outq u_outq (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (s1_valid_r),
    .push_data  (res_data),
    .pop        (out_tready),
    .head_valid (out_tvalid),
    .head_data  (head_data),
    .count      (oq_count)
  );

  assign out_tdata = {{(bgs_pkg::OUT_DATA_W - bgs_pkg::RES_W){1'b0}}, head_data};

endmodule

// ----- tb/tb_top.sv -----
`timescale 1ns / 100ps

module tb_top;

  // one pixel request as sent to the block
  typedef struct packed {
    bit            first;
    bit [2:0][7:0] s;
    bit [18:0]     idx;
  } pixel_req_t;

  // one mask result as returned by the block
  typedef struct packed {
    bit [2:0][7:0] bg;
    bit [2:0]      fg;
  } pixel_res_t;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_tvalid = 1'b0;
  logic        in_tready;
  logic [47:0] in_tdata = '0;
  logic        in_tuser = 1'b0;
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic [31:0] out_tdata;
  logic        cfg_valid = 1'b0;
  logic        cfg_ready;
  logic [1:0]  cfg_index = '0;
  logic [8:0]  cfg_data = '0;

  background_subtract_ghost_suppress_core uut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data)
  );

  always #5 clk = ~clk;

  // shadow of the configuration registers
  bit       mode_q  = bgs_pkg::RST_COLOR_MODE;
  bit [7:0] thr_q   = bgs_pkg::RST_DIFF_THRESHOLD;
  bit [8:0] alpha_q = bgs_pkg::RST_BLEND_WEIGHT;
  bit [8:0] limit_q = bgs_pkg::RST_GHOST_LIMIT;

  // per-pixel background and foreground counters, only written entries exist
  bit [2:0][7:0] bg_model    [bit [18:0]];
  bit [2:0][7:0] count_model [bit [18:0]];

  pixel_req_t pix_queue[$];
  pixel_res_t mask_expected[$];
  int         err_count = 0;
  bit         in_hs = 1'b0;
  int         in_gap = 0;
  int         out_stall = 0;
  bit         in_no_idle = 1'b0;
  bit         out_no_idle = 1'b0;
  bit [18:0]  keep_pool[16];

  // running average update, foreground decision and ghost replacement
  function automatic pixel_res_t update_pixel(pixel_req_t r);
    pixel_res_t    res;
    bit [2:0][7:0] bgv;
    bit [2:0][7:0] cnt;
    int            a, lim, b, p, nb, d, nch;
    bit [7:0]      c;
    res = '0;
    a   = (alpha_q > bgs_pkg::Q8_ONE) ? int'(bgs_pkg::Q8_ONE) : int'(alpha_q);
    lim = (limit_q > bgs_pkg::Q8_ONE) ? int'(bgs_pkg::Q8_ONE) : int'(limit_q);
    nch = mode_q ? 3 : 1;
    if (r.first) begin
      bg_model[r.idx]    = r.s;
      count_model[r.idx] = '0;
      for (int k = 0; k < nch; k++) res.bg[k] = r.s[k];
    end else begin
      bgv = bg_model[r.idx];
      cnt = count_model[r.idx];
      for (int k = 0; k < nch; k++) begin
        b  = bgv[k];
        p  = r.s[k];
        nb = (a * p + (int'(bgs_pkg::Q8_ONE) - a) * b + int'(bgs_pkg::Q8_HALF)) >> 8;
        d  = (nb > p) ? nb - p : p - nb;
        if (d > int'(thr_q)) begin
          res.fg[k] = 1'b1;
          c = cnt[k] + 8'd1;
          cnt[k] = c;
          if (int'(c) >= lim) nb = p;
        end else begin
          cnt[k] = '0;
        end
        bgv[k]    = nb[7:0];
        res.bg[k] = nb[7:0];
      end
      bg_model[r.idx]    = bgv;
      count_model[r.idx] = cnt;
    end
    return res;
  endfunction

  // idle length: mostly none or short, now and then long
  function automatic int pick_gap(bit no_idle);
    int r;
    if (no_idle) return 0;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 10);
    return $urandom_range(20, 40);
  endfunction

  // channel value near the background, near an object, or anywhere
  function automatic bit [7:0] pick_sample(bit [18:0] idx, int k, bit [7:0] obj);
    bit [2:0][7:0] cur;
    int            base, spread, r, v;
    cur    = bg_model[idx];
    base   = cur[k];
    spread = (int'(thr_q) + 4 > 64) ? 64 : int'(thr_q) + 4;
    r      = $urandom_range(0, 19);
    if (r < 8) v = base + int'($urandom_range(0, 2 * spread)) - spread;
    else if (r < 14) v = int'(obj) + int'($urandom_range(0, 4)) - 2;
    else if (r < 17) v = $urandom_range(0, 255);
    else if (r == 17) v = 0;
    else if (r == 18) v = 255;
    else v = base ^ 128;
    if (v < 0) v = 0;
    if (v > 255) v = 255;
    return v[7:0];
  endfunction

  task automatic send_pixel(bit [18:0] idx, bit first, bit [7:0] c0, bit [7:0] c1,
                            bit [7:0] c2);
    pixel_req_t r;
    r.idx   = idx;
    r.first = first;
    r.s     = {c2, c1, c0};
    mask_expected.push_back(update_pixel(r));
    pix_queue.push_back(r);
  endtask

  task automatic write_reg(logic [1:0] idx, logic [8:0] val);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    do @(posedge clk); while (!cfg_ready);
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  // block is idle here, so the shadow can follow each write directly
  task automatic set_config(bit cm, bit [7:0] thr, bit [8:0] alpha, bit [8:0] lim);
    write_reg(bgs_pkg::REG_COLOR_MODE, {8'd0, cm});
    mode_q = cm;
    write_reg(bgs_pkg::REG_DIFF_THRESHOLD, {1'b0, thr});
    thr_q = thr;
    write_reg(bgs_pkg::REG_BLEND_WEIGHT, alpha);
    alpha_q = alpha;
    write_reg(bgs_pkg::REG_GHOST_LIMIT, lim);
    limit_q = lim;
  endtask

  task automatic wait_idle();
    while (pix_queue.size() != 0 || mask_expected.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  // mostly update (not first-frame) pixel sequences on a small pool of positions
  task automatic run_random_phase(int n_items);
    bit [18:0] pool[8];
    bit [7:0]  obj[8][3];
    bit [7:0]  smp[3];
    bit [18:0] idx;
    bit        first;
    int        slot, prev;
    for (int i = 0; i < 8; i++) begin
      pool[i] = $urandom_range(0, 1) ? keep_pool[$urandom_range(0, 15)]
                                     : 19'($urandom_range(0, 524287));
      for (int k = 0; k < 3; k++) obj[i][k] = 8'($urandom_range(0, 255));
    end
    prev = 0;
    repeat (n_items) begin
      slot  = $urandom_range(0, 1) ? prev : $urandom_range(0, 7);
      prev  = slot;
      idx   = pool[slot];
      first = !bg_model.exists(idx) || ($urandom_range(0, 39) == 0);
      for (int k = 0; k < 3; k++)
        smp[k] = first ? 8'($urandom_range(0, 255)) : pick_sample(idx, k, obj[slot][k]);
      send_pixel(idx, first, smp[0], smp[1], smp[2]);
    end
  endtask

  // pixel request driver
  always @(posedge clk) begin
    in_hs <= rst_n && in_tvalid && in_tready;
  end

  always @(negedge clk) begin
    if (!rst_n) begin
      in_tvalid <= 1'b0;
    end else if (!in_tvalid || in_hs) begin
      if (in_gap > 0) begin
        in_gap    <= in_gap - 1;
        in_tvalid <= 1'b0;
      end else if (pix_queue.size() != 0) begin
        pixel_req_t r;
        r = pix_queue.pop_front();
        in_tdata  <= {5'd0, r.s, r.idx};
        in_tuser  <= r.first;
        in_tvalid <= 1'b1;
        in_gap    <= pick_gap(in_no_idle);
      end else begin
        in_tvalid <= 1'b0;
      end
    end
  end

  // result backpressure
  always @(negedge clk) begin
    if (!rst_n) begin
      out_tready <= 1'b0;
    end else if (out_stall > 0) begin
      out_stall  <= out_stall - 1;
      out_tready <= 1'b0;
    end else begin
      out_tready <= 1'b1;
      out_stall  <= pick_gap(out_no_idle);
    end
  end

  // result monitor
  always @(posedge clk) begin
    if (rst_n && out_tvalid && out_tready) begin
      if (mask_expected.size() == 0) begin
        $display("%0t: unexpected result, expected none, actual %h", $time, out_tdata);
        err_count++;
      end else begin
        pixel_res_t want;
        want = mask_expected.pop_front();
        for (int k = 0; k < 3; k++) begin
          if (out_tdata[k] !== want.fg[k]) begin
            $display("%0t: fg_ch%0d expected %0d actual %b", $time, k, want.fg[k],
                     out_tdata[k]);
            err_count++;
          end
          if (out_tdata[3 + 8 * k +: 8] !== want.bg[k]) begin
            $display("%0t: bg_ch%0d expected %0d actual %0d", $time, k, want.bg[k],
                     out_tdata[3 + 8 * k +: 8]);
            err_count++;
          end
        end
      end
    end
  end

  initial begin
    #(5_000_000);
    $display("[background_subtract_ghost_suppress_core] ERROR");
    $finish;
  end

  initial begin
    bit [18:0] ghost_idx;
    bit [2:0][7:0] cur;
    bit [7:0]  thr;
    bit [8:0]  alpha, lim;
    keep_pool[0] = 19'h00000;
    keep_pool[1] = 19'h7FFFF;
    keep_pool[2] = 19'h2AAAA;
    keep_pool[3] = 19'h55555;
    for (int i = 4; i < 16; i++) keep_pool[i] = 19'($urandom_range(0, 524287));

    repeat (6) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    repeat (2) @(posedge clk);

    // reset settings, gray mode: first frames at the extremes, then updates
    send_pixel(19'h00000, 1'b1, 8'h00, 8'h00, 8'h00);
    send_pixel(19'h7FFFF, 1'b1, 8'hFF, 8'hFF, 8'hFF);
    send_pixel(19'h2AAAA, 1'b1, 8'h55, 8'hAA, 8'hFF);
    send_pixel(19'h55555, 1'b1, 8'hAA, 8'h55, 8'h00);
    send_pixel(19'h00000, 1'b0, 8'hFF, 8'hFF, 8'hFF);
    send_pixel(19'h00000, 1'b0, 8'hFF, 8'h00, 8'hFF);
    send_pixel(19'h7FFFF, 1'b0, 8'h00, 8'h00, 8'h00);
    send_pixel(19'h2AAAA, 1'b0, 8'h55, 8'h00, 8'h00);
    send_pixel(19'h55555, 1'b0, 8'h80, 8'h80, 8'h80);
    wait_idle();

    // colour mode, alpha of one: background follows the pixel, never foreground
    set_config(1'b1, 8'd0, bgs_pkg::Q8_ONE, 9'd0);
    send_pixel(19'h00000, 1'b0, 8'hFF, 8'h00, 8'h80);
    send_pixel(19'h7FFFF, 1'b0, 8'h00, 8'hFF, 8'h80);
    send_pixel(19'h00000, 1'b1, 8'h12, 8'h34, 8'h56);
    send_pixel(19'h00000, 1'b0, 8'hFF, 8'h00, 8'hFF);
    wait_idle();

    // threshold at its top can never be exceeded
    set_config(1'b1, 8'd255, 9'd0, 9'd511);
    send_pixel(19'h2AAAA, 1'b0, 8'h00, 8'hFF, 8'h00);
    send_pixel(19'h55555, 1'b0, 8'hFF, 8'h00, 8'hFF);
    wait_idle();

    // blend weight above one saturates
    set_config(1'b1, 8'd10, 9'd511, 9'd3);
    send_pixel(19'h00000, 1'b0, 8'h00, 8'hFF, 8'h7F);
    wait_idle();

    // ghost limit zero replaces every foreground background at once
    set_config(1'b1, 8'd10, 9'd0, 9'd0);
    send_pixel(19'h00000, 1'b0, 8'hFF, 8'h00, 8'h80);
    send_pixel(19'h00000, 1'b0, 8'h00, 8'hFF, 8'h00);
    send_pixel(19'h7FFFF, 1'b0, 8'h00, 8'h00, 8'h00);
    wait_idle();

    // small ghost limit reached after a few foreground hits, gray mode
    set_config(1'b0, 8'd5, 9'd1, 9'd2);
    send_pixel(19'h55555, 1'b0, 8'hFF, 8'h00, 8'h00);
    send_pixel(19'h55555, 1'b0, 8'hFF, 8'h00, 8'h00);
    send_pixel(19'h55555, 1'b0, 8'hFF, 8'h00, 8'h00);
    wait_idle();

    for (int ph = 0; ph < 12; ph++) begin
      in_no_idle  = ($urandom_range(0, 3) == 0);
      out_no_idle = ($urandom_range(0, 3) == 0);
      if (ph == 5) begin
        // fixed background, every hit foreground, counter runs past its wrap
        set_config(1'b1, 8'd0, 9'd0, bgs_pkg::Q8_ONE);
        ghost_idx = keep_pool[$urandom_range(0, 3)];
        repeat (300) begin
          cur = bg_model[ghost_idx];
          send_pixel(ghost_idx, 1'b0, cur[0] ^ 8'h80, cur[1] ^ 8'h80, cur[2] ^ 8'h80);
        end
        wait_idle();
      end
      case ($urandom_range(0, 3))
        0:       thr = 8'd0;
        1:       thr = 8'd255;
        2:       thr = 8'($urandom_range(0, 40));
        default: thr = 8'($urandom_range(0, 255));
      endcase
      case ($urandom_range(0, 5))
        0:       alpha = 9'd0;
        1:       alpha = bgs_pkg::Q8_ONE;
        2:       alpha = 9'($urandom_range(257, 511));
        3:       alpha = 9'($urandom_range(0, 256));
        default: alpha = 9'($urandom_range(0, 64));
      endcase
      case ($urandom_range(0, 5))
        0:       lim = 9'd0;
        1:       lim = bgs_pkg::Q8_ONE;
        2:       lim = 9'($urandom_range(257, 511));
        3:       lim = 9'($urandom_range(0, 60));
        default: lim = 9'($urandom_range(1, 8));
      endcase
      set_config(1'($urandom_range(0, 1)), thr, alpha, lim);
      run_random_phase(112);
      wait_idle();
    end

    while (pix_queue.size() != 0 || mask_expected.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);
    if (err_count == 0) begin
      $display("[background_subtract_ghost_suppress_core] OK");
    end else begin
      $display("[background_subtract_ghost_suppress_core] ERROR");
    end
    $finish;
  end

endmodule

// ----- background_subtract_ghost_suppress_core.f -----
rtl/bgs_pkg.sv
rtl/bgs_mem.sv
rtl/bgs_chan.sv
rtl/bgs_outq.sv
rtl/background_subtract_ghost_suppress_core.sv
tb/tb_top.sv
